// ===== hw/rtl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and the digit-to-ASCII mapping for the radix
// digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned IDX_W       = $clog2(VALUE_WIDTH);
  localparam int unsigned STEP_W      = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [DIGIT_W-1:0] DIGIT_DEC_LIMIT = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT     = DIGIT_W'(36);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO       = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA_OFS  = CHAR_W'(55);

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_DEC_LIMIT) begin
      c = CHAR_ZERO + {1'b0, d};
    end else if (d < DIGIT_LIMIT) begin
      c = CHAR_ALPHA_OFS + {1'b0, d};
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rdc_divider.sv =====
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring serial divider: one quotient bit per cycle; done pulses in the
// cycle after the final step.
// ----------------------------------------------------------------------------
module rdc_divider import rdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [RADIX_W-1:0]     div_q, div_d;

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic             ge;

  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (busy_q) begin
      quo_d  = {quo_q[VALUE_WIDTH-2:0], ge};
      rem_d  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(VALUE_WIDTH - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== hw/rtl/rdc_digit_store.sv =====
// ----------------------------------------------------------------------------
// rdc_digit_store
// Digit memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdc_digit_store import rdc_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [DIGIT_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output logic [DIGIT_W-1:0] rd_data_o
);

  logic [DIGIT_W-1:0] mem_q [VALUE_WIDTH];
  logic [DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/radix_digit_converter_core.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts an unsigned value to ASCII digits in radix 2..36, most
// significant first, with last set on the final digit.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall_o stays high until the last digit
// has been taken. Each digit is computed in the shared serial divider
// (one quotient bit per cycle) and written to the digit memory; once all
// digits are stored, each is read back (S_RD) and presented (S_OUT).
// A zero value, or a radix outside 2..36, yields no output words and
// leaves the input open, as the core stays in S_IDLE.
module radix_digit_converter_core import rdc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [RADIX_W-1:0]     radix_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CHAR_W-1:0]      digit_char_o,
  output logic                   last_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   cnt_m1;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               st_we;
  logic               st_rd_en;
  logic [DIGIT_W-1:0] st_rd_data;

  logic in_acc;
  logic out_acc;
  logic radix_ok;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign radix_ok = (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX);
  assign cnt_m1   = cnt_q - CNT_W'(1);

  always_comb begin
    state_d          = state_q;
    radix_d          = radix_q;
    cnt_d            = cnt_q;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = radix_q;
    st_we            = 1'b0;
    st_rd_en         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        div_req.dividend = value_i;
        div_req.divisor  = radix_i;
        if (in_acc && radix_ok && (value_i != '0)) begin
          div_req.start = 1'b1;
          radix_d       = radix_i;
          cnt_d         = '0;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          st_we = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
          if ((div_rsp.quotient == '0) || (cnt_q == CNT_W'(VALUE_WIDTH - 1))) begin
            state_d = S_RD;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      S_RD: begin
        st_rd_en = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          cnt_d   = cnt_m1;
          state_d = (cnt_q == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
  end

  rdc_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rdc_digit_store u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .wr_addr_i (cnt_q[IDX_W-1:0]),
    .wr_data_i (div_rsp.remainder),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (cnt_m1[IDX_W-1:0]),
    .rd_data_o (st_rd_data)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign digit_char_o = digit_to_char(st_rd_data);
  assign last_o       = (cnt_q == CNT_W'(1));

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("output word while input open");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && !out_stall_i) |=> (!out_valid_o && !in_stall_o))
    else $error("item not finished after last word");

  a_no_word_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o &&
     ((radix_i < RADIX_MIN) || (radix_i > RADIX_MAX) || (value_i == '0)))
    |=> (!in_stall_o && !out_valid_o))
    else $error("ignored item started work");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(VALUE_WIDTH))
    else $error("digit count out of range");

endmodule
